// ----- hw/rtl/touch_event_to_screen_point_top_assert.svh -----
// Assertion macros shared by the touch point converter RTL.
`ifndef TOUCH_EVENT_TO_SCREEN_POINT_TOP_ASSERT_SVH
`define TOUCH_EVENT_TO_SCREEN_POINT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TESP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define TESP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Implication after the point pipeline fill latency.
`define TESP_ASSERT_LAT3(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/tesp_pkg.sv -----
// Shared codes and types of the touch point converter.
package tesp_pkg;

    localparam logic [4:0] KIND_SYN = 5'd0;
    localparam logic [4:0] KIND_KEY = 5'd1;
    localparam logic [4:0] KIND_ABS = 5'd3;

    localparam logic [9:0] CODE_X         = 10'd0;
    localparam logic [9:0] CODE_Y         = 10'd1;
    localparam logic [9:0] CODE_PRESSURE  = 10'd24;
    localparam logic [9:0] CODE_MT_SLOT   = 10'd47;
    localparam logic [9:0] CODE_MT_X      = 10'd53;
    localparam logic [9:0] CODE_MT_Y      = 10'd54;
    localparam logic [9:0] CODE_MT_ID     = 10'd57;
    localparam logic [9:0] CODE_BTN_LEFT  = 10'd272;
    localparam logic [9:0] CODE_BTN_TOUCH = 10'd330;
    localparam logic [9:0] CODE_SYN_REPORT = 10'd0;

    localparam logic [31:0] RELEASE_ID = 32'hFFFF_FFFF;
    localparam logic [31:0] KEY_DOWN   = 32'd1;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_X_GAIN   = 3'd0;
    localparam logic [2:0] REG_Y_GAIN   = 3'd1;
    localparam logic [2:0] REG_X_OFFSET = 3'd2;
    localparam logic [2:0] REG_Y_OFFSET = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;
    localparam logic [2:0] REG_MODE     = 3'd6;

    // transform_mode bits
    localparam int TM_SWAP  = 0;
    localparam int TM_INV_X = 1;
    localparam int TM_INV_Y = 2;
    localparam int TM_MT    = 3;

    localparam int SLOT_W = 48;  // {id, y, x}

    typedef struct packed {
        logic        valid;
        logic [9:0]  code;
        logic [31:0] value;
    } mt_evt_t;

endpackage

// ----- hw/rtl/tesp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module tesp_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read-first: a same-cycle write is not seen
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/tesp_scale.sv -----
// Two-stage axis scaler: raw * Q8.16 gain, then offset, truncate, saturate.
module tesp_scale import tesp_pkg::*; (
    input  logic               clk,
    input  logic               ld_mul,
    input  logic               ld_sat,
    input  logic signed [15:0] raw,
    input  logic [23:0]        gain,
    input  logic signed [15:0] offset,
    output logic signed [15:0] coord
);

    logic signed [24:0] gain_s;
    logic signed [40:0] prod_next;
    logic signed [40:0] prod_reg;
    logic signed [25:0] q_floor;
    logic signed [25:0] q_trunc;
    logic signed [15:0] coord_next;
    logic signed [15:0] coord_reg;

    assign gain_s    = signed'({1'b0, gain});
    assign prod_next = raw * gain_s;

    always_ff @(posedge clk)
    begin
        if (ld_mul)
        begin
            prod_reg <= prod_next;
        end
    end

    // low 16 bits of the sum equal those of the product
    assign q_floor = 26'(prod_reg >>> 16) + 26'(offset);
    assign q_trunc = q_floor + 26'((q_floor < 0 && prod_reg[15:0] != 16'd0) ? 1 : 0);

    always_comb
    begin
        if (q_trunc > 26'sd32767)
        begin
            coord_next = 16'sh7FFF;
        end
        else if (q_trunc < -26'sd32768)
        begin
            coord_next = 16'sh8000;
        end
        else
        begin
            coord_next = q_trunc[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_sat)
        begin
            coord_reg <= coord_next;
        end
    end

    assign coord = coord_reg;

endmodule

// ----- hw/rtl/tesp_slot.sv -----
// Multitouch slot tracker: slot select, pending position, slot table RAM.
module tesp_slot import tesp_pkg::*; #(
    parameter int SLOT_COUNT = 16,
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
    localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mt_evt_t               mt_evt,
    output logic [SLOT_COUNT-1:0] slot_pressed,
    output logic [CNT_W-1:0]      live_count
);

    logic [IDX_W-1:0]      slot_index_reg, slot_index_next;
    logic                  slot_valid_reg, slot_valid_next;
    logic [15:0]           pend_x_reg, pend_x_next;
    logic [15:0]           pend_y_reg, pend_y_next;
    logic [SLOT_COUNT-1:0] pressed_reg, pressed_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [SLOT_COUNT-1:0] tbl_valid_reg, tbl_valid_next;

    // read-modify-write stage
    logic                  m_v_reg;
    logic                  m_release_reg;
    logic [IDX_W-1:0]      m_addr_reg;
    logic [SLOT_W-1:0]     m_data_reg;

    // last write, for forwarding
    logic                  lw_v_reg;
    logic [IDX_W-1:0]      lw_addr_reg;
    logic [SLOT_W-1:0]     lw_data_reg;

    logic                  is_select, slot_ok, slot_act, id_act, is_release, cur_bit;
    logic [SLOT_W-1:0]     rd_data, old_entry, wr_data;

    assign is_select  = mt_evt.valid && (mt_evt.code == CODE_MT_SLOT);
    assign slot_ok    = !mt_evt.value[31] && (mt_evt.value < 32'(SLOT_COUNT));
    assign slot_act   = mt_evt.valid && slot_valid_reg && (mt_evt.code != CODE_MT_SLOT);
    assign id_act     = slot_act && (mt_evt.code == CODE_MT_ID);
    assign is_release = (mt_evt.value == RELEASE_ID);
    assign cur_bit    = pressed_reg[slot_index_reg];

    always_comb
    begin
        slot_index_next = slot_index_reg;
        slot_valid_next = slot_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pressed_next    = pressed_reg;
        count_next      = count_reg;
        if (is_select)
        begin
            slot_valid_next = slot_ok;
            if (slot_ok)
            begin
                slot_index_next = mt_evt.value[IDX_W-1:0];
            end
        end
        if (slot_act && mt_evt.code == CODE_MT_X)
        begin
            pend_x_next = mt_evt.value[15:0];
        end
        if (slot_act && mt_evt.code == CODE_MT_Y)
        begin
            pend_y_next = mt_evt.value[15:0];
        end
        if (id_act)
        begin
            pressed_next[slot_index_reg] = !is_release;
            if (is_release && cur_bit)
            begin
                count_next = count_reg - CNT_W'(1);
            end
            else if (!is_release && !cur_bit)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    tesp_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_table (
        .clk   (clk),
        .we    (m_v_reg),
        .waddr (m_addr_reg),
        .wdata (wr_data),
        .re    (id_act),
        .raddr (slot_index_reg),
        .rdata (rd_data)
    );

    // back-to-back writes to one entry: the RAM copy is one write behind
    always_comb
    begin
        if (lw_v_reg && lw_addr_reg == m_addr_reg)
        begin
            old_entry = lw_data_reg;
        end
        else if (tbl_valid_reg[m_addr_reg])
        begin
            old_entry = rd_data;
        end
        else
        begin
            old_entry = '0;
        end
    end

    assign wr_data = m_release_reg ? {16'd0, old_entry[31:0]} : m_data_reg;

    always_comb
    begin
        tbl_valid_next = tbl_valid_reg;
        if (m_v_reg)
        begin
            tbl_valid_next[m_addr_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_index_reg <= '0;
            slot_valid_reg <= 1'b0;
            pend_x_reg     <= '0;
            pend_y_reg     <= '0;
            pressed_reg    <= '0;
            count_reg      <= '0;
            tbl_valid_reg  <= '0;
            m_v_reg        <= 1'b0;
            lw_v_reg       <= 1'b0;
        end
        else
        begin
            slot_index_reg <= slot_index_next;
            slot_valid_reg <= slot_valid_next;
            pend_x_reg     <= pend_x_next;
            pend_y_reg     <= pend_y_next;
            pressed_reg    <= pressed_next;
            count_reg      <= count_next;
            tbl_valid_reg  <= tbl_valid_next;
            m_v_reg        <= id_act;
            lw_v_reg       <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (id_act)
        begin
            m_release_reg <= is_release;
            m_addr_reg    <= slot_index_reg;
            m_data_reg    <= {mt_evt.value[15:0], pend_y_reg, pend_x_reg};
        end
        if (m_v_reg)
        begin
            lw_addr_reg <= m_addr_reg;
            lw_data_reg <= wr_data;
        end
    end

    assign slot_pressed = pressed_reg;
    assign live_count   = count_reg;

endmodule

// ----- hw/rtl/touch_event_to_screen_point_top.sv -----
// Top level of the touch event to screen point converter.
//
// Usage:
//   Input channel (in_valid/in_ready): one input event per item: ev_kind,
//   ev_code, ev_value, stamp_ms. Axis, pressure, key and multitouch events
//   update internal state at the edge they are accepted and give no item.
//   A sync report (kind 0, code 0) gives exactly one output item.
//   Output channel (out_valid/out_ready): out_x, out_y, touch_pressed,
//   touch_pressure, event_time_ms, active_points.
//   Config: APB-style write/read port, registers at 4*index, pready tied high.
// Path: a sync report passes the multiply stage, offset/saturate stage and
//   transform/clamp output register. Throughput: 1 item per cycle while
//   in_ready is high; the three point stages advance independently, so
//   bubbles collapse and input stays open while a finished point waits.
// Stall: when out_ready is low the point stays in the output register;
//   in_ready drops only once the first stage is full and cannot move.
// Reset: all event state, slot flags and pipeline valids clear; config
//   registers take their defaults. Slot table entries read as zero until
//   written (per-entry valid flags), so no clearing pass is needed.
module touch_event_to_screen_point_top import tesp_pkg::*; #(
    parameter int SLOT_COUNT = 16
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         ev_kind,
    input  logic [9:0]         ev_code,
    input  logic signed [31:0] ev_value,
    input  logic [31:0]        stamp_ms,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [14:0]        out_x,
    output logic [14:0]        out_y,
    output logic               touch_pressed,
    output logic signed [15:0] touch_pressure,
    output logic [31:0]        event_time_ms,
    output logic [4:0]         active_points
);

`include "touch_event_to_screen_point_top_assert.svh"

    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // ---------------- configuration registers ----------------
    logic [23:0]        x_gain_reg, y_gain_reg;
    logic signed [15:0] x_offset_reg, y_offset_reg;
    logic [14:0]        display_width_reg, display_height_reg;
    logic [3:0]         transform_mode_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_gain_reg         <= 24'd3840;
            y_gain_reg         <= 24'd2160;
            x_offset_reg       <= '0;
            y_offset_reg       <= '0;
            display_width_reg  <= 15'd1920;
            display_height_reg <= 15'd1080;
            transform_mode_reg <= 4'd8;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_X_GAIN:   x_gain_reg         <= pwdata[23:0];
                REG_Y_GAIN:   y_gain_reg         <= pwdata[23:0];
                REG_X_OFFSET: x_offset_reg       <= pwdata[15:0];
                REG_Y_OFFSET: y_offset_reg       <= pwdata[15:0];
                REG_WIDTH:    display_width_reg  <= pwdata[14:0];
                REG_HEIGHT:   display_height_reg <= pwdata[14:0];
                REG_MODE:     transform_mode_reg <= pwdata[3:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_X_GAIN:   prdata = {8'd0, x_gain_reg};
            REG_Y_GAIN:   prdata = {8'd0, y_gain_reg};
            REG_X_OFFSET: prdata = 32'(x_offset_reg);
            REG_Y_OFFSET: prdata = 32'(y_offset_reg);
            REG_WIDTH:    prdata = {17'd0, display_width_reg};
            REG_HEIGHT:   prdata = {17'd0, display_height_reg};
            REG_MODE:     prdata = {28'd0, transform_mode_reg};
            default:      prdata = '0;
        endcase
    end

    // ---------------- event decode and scalar state ----------------
    logic               in_acc, is_abs, is_key, sync_acc, mt_on;
    logic signed [15:0] axis_x_reg, axis_y_reg, press_level_reg;
    logic               contact_down_reg;
    logic [4:0]         held_count_reg, held_count_next;
    logic [7:0]         live8;
    mt_evt_t            mt_evt;
    logic [SLOT_COUNT-1:0] slot_pressed;
    logic [CNT_W-1:0]   live_count;

    assign in_acc   = in_valid && in_ready;
    assign is_abs   = ev_kind == KIND_ABS;
    assign is_key   = ev_kind == KIND_KEY;
    assign sync_acc = in_acc && ev_kind == KIND_SYN && ev_code == CODE_SYN_REPORT;
    assign mt_on    = transform_mode_reg[TM_MT];

    // any other absolute code goes to the slot tracker when multitouch is on
    assign mt_evt.valid = in_acc && is_abs && mt_on && ev_code != CODE_X
                          && ev_code != CODE_Y && ev_code != CODE_PRESSURE;
    assign mt_evt.code  = ev_code;
    assign mt_evt.value = ev_value;

    tesp_slot #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slot (
        .clk          (clk),
        .rst_n        (rst_n),
        .mt_evt       (mt_evt),
        .slot_pressed (slot_pressed),
        .live_count   (live_count)
    );

    // count saturates at 31; held while multitouch is off
    assign live8 = 8'(live_count);
    always_comb
    begin
        held_count_next = held_count_reg;
        if (sync_acc && mt_on)
        begin
            held_count_next = (live8 > 8'd31) ? 5'd31 : live8[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_x_reg       <= '0;
            axis_y_reg       <= '0;
            press_level_reg  <= '0;
            contact_down_reg <= 1'b0;
            held_count_reg   <= '0;
        end
        else
        begin
            held_count_reg <= held_count_next;
            if (in_acc && is_abs && ev_code == CODE_X)
            begin
                axis_x_reg <= ev_value[15:0];
            end
            if (in_acc && is_abs && ev_code == CODE_Y)
            begin
                axis_y_reg <= ev_value[15:0];
            end
            if (in_acc && is_abs && ev_code == CODE_PRESSURE)
            begin
                press_level_reg <= ev_value[15:0];
            end
            if (in_acc && is_key && (ev_code == CODE_BTN_TOUCH || ev_code == CODE_BTN_LEFT))
            begin
                contact_down_reg <= (ev_value == KEY_DOWN);
            end
        end
    end

    // ---------------- point pipeline ----------------
    logic               p1_v_reg, p2_v_reg, out_valid_reg;
    logic               out_free, p2_move, p2_free, p1_move, p1_free;
    logic               p1_pressed_reg, p2_pressed_reg;
    logic signed [15:0] p1_pressure_reg, p2_pressure_reg;
    logic [31:0]        p1_stamp_reg, p2_stamp_reg;
    logic [4:0]         p1_count_reg, p2_count_reg;
    logic signed [15:0] sx, sy, fx, fy;
    logic signed [17:0] tx, ty;
    logic [14:0]        out_x_reg, out_y_reg;
    logic               out_pressed_reg;
    logic signed [15:0] out_pressure_reg;
    logic [31:0]        out_stamp_reg;
    logic [4:0]         out_count_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign p2_move  = p2_v_reg && out_free;
    assign p2_free  = !p2_v_reg || out_free;
    assign p1_move  = p1_v_reg && p2_free;
    assign p1_free  = !p1_v_reg || p2_free;
    assign in_ready = p1_free;

    tesp_scale u_scale_x (
        .clk    (clk),
        .ld_mul (sync_acc),
        .ld_sat (p1_move),
        .raw    (axis_x_reg),
        .gain   (x_gain_reg),
        .offset (x_offset_reg),
        .coord  (sx)
    );

    tesp_scale u_scale_y (
        .clk    (clk),
        .ld_mul (sync_acc),
        .ld_sat (p1_move),
        .raw    (axis_y_reg),
        .gain   (y_gain_reg),
        .offset (y_offset_reg),
        .coord  (sy)
    );

    function automatic logic [14:0] clamp_dim(input logic signed [17:0] v,
                                              input logic [14:0] dim);
        logic signed [17:0] dim_s;
        dim_s = signed'({3'd0, dim});
        if (dim == 15'd0 || v < 0)
        begin
            return 15'd0;
        end
        else if (v >= dim_s)
        begin
            return dim - 15'd1;
        end
        return v[14:0];
    endfunction

    // swap, then optional invert against the screen size
    assign fx = transform_mode_reg[TM_SWAP] ? sy : sx;
    assign fy = transform_mode_reg[TM_SWAP] ? sx : sy;
    assign tx = transform_mode_reg[TM_INV_X] ?
                signed'({3'd0, display_width_reg}) - 18'(fx) : 18'(fx);
    assign ty = transform_mode_reg[TM_INV_Y] ?
                signed'({3'd0, display_height_reg}) - 18'(fy) : 18'(fy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sync_acc)
            begin
                p1_v_reg <= 1'b1;
            end
            else if (p1_move)
            begin
                p1_v_reg <= 1'b0;
            end
            if (p1_move)
            begin
                p2_v_reg <= 1'b1;
            end
            else if (p2_move)
            begin
                p2_v_reg <= 1'b0;
            end
            if (p2_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sync_acc)
        begin
            p1_pressed_reg  <= contact_down_reg;
            p1_pressure_reg <= press_level_reg;
            p1_stamp_reg    <= stamp_ms;
            p1_count_reg    <= held_count_next;
        end
        if (p1_move)
        begin
            p2_pressed_reg  <= p1_pressed_reg;
            p2_pressure_reg <= p1_pressure_reg;
            p2_stamp_reg    <= p1_stamp_reg;
            p2_count_reg    <= p1_count_reg;
        end
        if (p2_move)
        begin
            out_x_reg        <= clamp_dim(tx, display_width_reg);
            out_y_reg        <= clamp_dim(ty, display_height_reg);
            out_pressed_reg  <= p2_pressed_reg;
            out_pressure_reg <= p2_pressure_reg;
            out_stamp_reg    <= p2_stamp_reg;
            out_count_reg    <= p2_count_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign touch_pressed  = out_pressed_reg;
    assign touch_pressure = out_pressure_reg;
    assign event_time_ms  = out_stamp_reg;
    assign active_points  = out_count_reg;

    // ---------------- checks ----------------
    `TESP_ASSERT_SAME(a_count_tracks_flags, 1'b1,
        $countones(slot_pressed) == int'(live_count),
        "live slot count out of step with pressed flags")
    `TESP_ASSERT_SAME(a_x_on_screen, out_valid && display_width_reg != 15'd0,
        out_x < display_width_reg, "out_x beyond screen width")
    `TESP_ASSERT_LAT3(a_empty_latency,
        sync_acc && !p1_v_reg && !p2_v_reg && !out_valid_reg,
        out_valid, "sync report not delivered after three cycles")

endmodule

// ----- tb/tb_touch_event_to_screen_point_top.sv -----
// Self-checking testbench for the touch event to screen point converter.
module tb_touch_event_to_screen_point_top import tesp_pkg::*;;

    // Block configuration and run control.
    localparam int SLOTS         = 16;
    localparam int SETTLE_CYCLES = 6;       // point pipeline is 3 deep, plus margin
    localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
    localparam int MAX_GAP       = 8;       // longest sender pause per item

    // One screen point as the block presents it.
    typedef struct packed {
        logic [14:0]        x;
        logic [14:0]        y;
        logic               pressed;
        logic signed [15:0] pressure;
        logic [31:0]        stamp;
        logic [4:0]         active;
    } screen_point_t;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic [4:0]         ev_kind;
    logic [9:0]         ev_code;
    logic signed [31:0] ev_value;
    logic [31:0]        stamp_ms;
    logic               out_valid;
    logic               out_ready;
    logic [14:0]        out_x;
    logic [14:0]        out_y;
    logic               touch_pressed;
    logic signed [15:0] touch_pressure;
    logic [31:0]        event_time_ms;
    logic [4:0]         active_points;

    touch_event_to_screen_point_top #(.SLOT_COUNT(SLOTS)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .ev_kind        (ev_kind),
        .ev_code        (ev_code),
        .ev_value       (ev_value),
        .stamp_ms       (stamp_ms),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_x          (out_x),
        .out_y          (out_y),
        .touch_pressed  (touch_pressed),
        .touch_pressure (touch_pressure),
        .event_time_ms  (event_time_ms),
        .active_points  (active_points)
    );

    // Shadow copy of the configuration registers.
    logic [23:0]        cfg_x_gain;
    logic [23:0]        cfg_y_gain;
    logic signed [15:0] cfg_x_offset;
    logic signed [15:0] cfg_y_offset;
    logic [14:0]        cfg_width;
    logic [14:0]        cfg_height;
    logic [3:0]         cfg_mode;

    // Shadow copy of the event state that reaches a point.
    logic signed [15:0] trk_axis_x;
    logic signed [15:0] trk_axis_y;
    logic signed [15:0] trk_pressure;
    logic               trk_down;
    logic [5:0]         trk_slot;
    logic               trk_slot_ok;
    logic [SLOTS-1:0]   trk_pressed;
    logic [4:0]         trk_held;

    screen_point_t expected_points[$];
    int            mismatch_count;
    int            cycle_count;
    int            items_counted;   // absolute, touch-key and sync report items sent
    int            send_idle_pct;
    int            recv_idle_pct;

    // Clock: period of 2 time units.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Run limit; a hang ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles at %0t", cycle_count, $time);
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Point prediction
    // ------------------------------------------------------------------

    // raw*gain in Q8.16 plus offset, truncated toward zero, saturated to 16 bits.
    function automatic int scale_coord(logic signed [15:0] raw, logic [23:0] gain,
                                       logic signed [15:0] off);
        longint acc;
        longint q;
        acc = longint'(raw) * longint'(gain) + longint'(off) * 64'sd65536;
        q = acc / 64'sd65536;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return int'(q);
    endfunction

    // Clamp to [0, dim-1]; a zero dimension pins the coordinate to 0.
    function automatic logic [14:0] fit_screen(int v, logic [14:0] dim);
        if (dim == 15'd0 || v < 0)
            return 15'd0;
        if (v >= int'(dim))
            return dim - 15'd1;
        return v[14:0];
    endfunction

    task automatic clear_track_state();
        trk_axis_x   = '0;
        trk_axis_y   = '0;
        trk_pressure = '0;
        trk_down     = 1'b0;
        trk_slot     = '0;
        trk_slot_ok  = 1'b0;
        trk_pressed  = '0;
        trk_held     = '0;
        cfg_x_gain   = 24'd3840;
        cfg_y_gain   = 24'd2160;
        cfg_x_offset = '0;
        cfg_y_offset = '0;
        cfg_width    = 15'd1920;
        cfg_height   = 15'd1080;
        cfg_mode     = 4'd8;
    endtask

    // Apply one accepted event to the shadow state; a sync report queues a point.
    task automatic predict_event(logic [4:0] kind, logic [9:0] code,
                                 logic signed [31:0] value, logic [31:0] stamp);
        screen_point_t pt;
        int            fx;
        int            fy;
        int            swap_tmp;
        if (kind == KIND_ABS)
        begin
            items_counted++;
            if (code == CODE_X)
                trk_axis_x = value[15:0];
            else if (code == CODE_Y)
                trk_axis_y = value[15:0];
            else if (code == CODE_PRESSURE)
                trk_pressure = value[15:0];
            else if (cfg_mode[TM_MT])
            begin
                if (code == CODE_MT_SLOT)
                begin
                    // negative and too-large slots drop the selection
                    if (value >= 0 && value < SLOTS)
                    begin
                        trk_slot    = value[5:0];
                        trk_slot_ok = 1'b1;
                    end
                    else
                        trk_slot_ok = 1'b0;
                end
                else if (code == CODE_MT_ID && trk_slot_ok)
                begin
                    if (value == RELEASE_ID)
                        trk_pressed[trk_slot] = 1'b0;
                    else
                        trk_pressed[trk_slot] = 1'b1;
                end
            end
        end
        else if (kind == KIND_KEY)
        begin
            if (code == CODE_BTN_TOUCH || code == CODE_BTN_LEFT)
            begin
                items_counted++;
                trk_down = (value == KEY_DOWN);
            end
        end
        else if (kind == KIND_SYN && code == CODE_SYN_REPORT)
        begin
            items_counted++;
            fx = scale_coord(trk_axis_x, cfg_x_gain, cfg_x_offset);
            fy = scale_coord(trk_axis_y, cfg_y_gain, cfg_y_offset);
            if (cfg_mode[TM_SWAP])
            begin
                swap_tmp = fx;
                fx       = fy;
                fy       = swap_tmp;
            end
            if (cfg_mode[TM_INV_X])
                fx = int'(cfg_width) - fx;
            if (cfg_mode[TM_INV_Y])
                fy = int'(cfg_height) - fy;
            // count is refreshed only while multitouch is on
            if (cfg_mode[TM_MT])
                trk_held = ($countones(trk_pressed) > 31) ? 5'd31 : 5'($countones(trk_pressed));
            pt.x        = fit_screen(fx, cfg_width);
            pt.y        = fit_screen(fy, cfg_height);
            pt.pressed  = trk_down;
            pt.pressure = trk_pressure;
            pt.stamp    = stamp;
            pt.active   = trk_held;
            expected_points.push_back(pt);
        end
    endtask

    // ------------------------------------------------------------------
    // Point checker
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Receiver stalls at random; ready changes on the falling edge only.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin : point_checker
        screen_point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point, expected none, actual x=%0d y=%0d stamp=%0h",
                         $time, out_x, out_y, event_time_ms);
                mismatch_count++;
            end
            else
            begin
                want = expected_points.pop_front();
                check_field("out_x", 32'(want.x), 32'(out_x));
                check_field("out_y", 32'(want.y), 32'(out_y));
                check_field("touch_pressed", 32'(want.pressed), 32'(touch_pressed));
                check_field("touch_pressure", 32'(unsigned'(want.pressure)),
                            32'(unsigned'(touch_pressure)));
                check_field("event_time_ms", want.stamp, event_time_ms);
                check_field("active_points", 32'(want.active), 32'(active_points));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Send one event item. Called and returns at a falling edge; valid is
    // left high so a back-to-back item needs only one assignment.
    task automatic send_event(logic [4:0] kind, logic [9:0] code,
                              logic signed [31:0] value, logic [31:0] stamp);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ev_kind  <= kind;
        ev_code  <= code;
        ev_value <= value;
        stamp_ms <= stamp;
        do
            @(posedge clk);
        while (!in_ready);
        predict_event(kind, code, value, stamp);
        @(negedge clk);
    endtask

    // Stop sending and wait until every queued point has come out, then
    // let the pipeline settle so non-point items are surely absorbed.
    task automatic wait_for_points();
        in_valid <= 1'b0;
        @(negedge clk);
        while (expected_points.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle; block must be idle.
    task automatic write_register(logic [2:0] idx, logic [31:0] data);
        logic [31:0] mask;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (idx)
            REG_X_GAIN:   cfg_x_gain   = data[23:0];
            REG_Y_GAIN:   cfg_y_gain   = data[23:0];
            REG_X_OFFSET: cfg_x_offset = data[15:0];
            REG_Y_OFFSET: cfg_y_offset = data[15:0];
            REG_WIDTH:    cfg_width    = data[14:0];
            REG_HEIGHT:   cfg_height   = data[14:0];
            REG_MODE:     cfg_mode     = data[3:0];
            default:      ;
        endcase
        @(negedge clk);
        // read path shows the value just written
        case (idx)
            REG_X_GAIN, REG_Y_GAIN:     mask = 32'h00FF_FFFF;
            REG_X_OFFSET, REG_Y_OFFSET: mask = 32'h0000_FFFF;
            REG_WIDTH, REG_HEIGHT:      mask = 32'h0000_7FFF;
            default:                    mask = 32'h0000_000F;
        endcase
        check_field("prdata", data & mask, prdata & mask);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_setting(logic [23:0] xg, logic [23:0] yg,
                                logic signed [15:0] xo, logic signed [15:0] yo,
                                logic [14:0] w, logic [14:0] h, logic [3:0] mode);
        wait_for_points();
        write_register(REG_X_GAIN, 32'(xg));
        write_register(REG_Y_GAIN, 32'(yg));
        write_register(REG_X_OFFSET, 32'(unsigned'(xo)));
        write_register(REG_Y_OFFSET, 32'(unsigned'(yo)));
        write_register(REG_WIDTH, 32'(w));
        write_register(REG_HEIGHT, 32'(h));
        write_register(REG_MODE, 32'(mode));
    endtask

    // Raw axis value: sensor-like half the time, else full width or extremes.
    function automatic logic [31:0] pick_axis();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return 32'($urandom_range(4095));
            2:       return 32'(-int'($urandom_range(400)));
            default: return $urandom_range(1) ? 32'h0000_7FFF : 32'hFFFF_8000;
        endcase
    endfunction

    // One report: optional slot traffic, axes, pressure, key, then a sync in most frames.
    task automatic send_touch_frame();
        logic signed [31:0] slot;
        logic signed [31:0] track_id;
        if ($urandom_range(3) != 0)
        begin
            case ($urandom_range(9))
                0:       slot = $urandom;
                1:       slot = -int'($urandom_range(1, 3));
                2:       slot = SLOTS + $urandom_range(47);
                default: slot = $urandom_range(SLOTS - 1);
            endcase
            send_event(KIND_ABS, CODE_MT_SLOT, slot, $urandom);
        end
        if ($urandom_range(1))
            send_event(KIND_ABS, CODE_MT_X, pick_axis(), $urandom);
        if ($urandom_range(1))
            send_event(KIND_ABS, CODE_MT_Y, pick_axis(), $urandom);
        if ($urandom_range(1))
        begin
            case ($urandom_range(3))
                0:       track_id = RELEASE_ID;
                1:       track_id = RELEASE_ID;
                2:       track_id = $urandom;
                default: track_id = $urandom_range(500);
            endcase
            send_event(KIND_ABS, CODE_MT_ID, track_id, $urandom);
        end
        if ($urandom_range(4) != 0)
            send_event(KIND_ABS, CODE_X, pick_axis(), $urandom);
        if ($urandom_range(4) != 0)
            send_event(KIND_ABS, CODE_Y, pick_axis(), $urandom);
        if ($urandom_range(2) == 0)
            send_event(KIND_ABS, CODE_PRESSURE, pick_axis(), $urandom);
        if ($urandom_range(2) == 0)
            send_event(KIND_KEY, $urandom_range(1) ? CODE_BTN_TOUCH : CODE_BTN_LEFT,
                       $urandom_range(3) ? 32'($urandom_range(2)) : $urandom, $urandom);
        // an occasional frame is left unterminated
        if ($urandom_range(15) != 0)
            send_event(KIND_SYN, CODE_SYN_REPORT, $urandom, $urandom);
    endtask

    // Anything at all: unknown kinds and codes, odd sync codes.
    task automatic send_noise_item();
        send_event(5'($urandom_range(31)), 10'($urandom_range(1023)), $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Sync straight after reset gives a point with zero coordinates, pressure and count at default config.
    task automatic test_power_on_point();
        send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0, 32'h0000_0001);
    endtask

    // Slot table: no selection yet, out-of-range selects, press and release.
    task automatic test_slot_table();
        send_event(KIND_ABS, CODE_MT_ID, 32'sd7, 32'd10);         // no slot selected
        send_event(KIND_ABS, CODE_MT_SLOT, -32'sd1, 32'd11);      // negative slot
        send_event(KIND_ABS, CODE_MT_ID, 32'sd8, 32'd12);
        send_event(KIND_ABS, CODE_MT_SLOT, 32'(SLOTS), 32'd13);   // one past the last slot
        send_event(KIND_ABS, CODE_MT_ID, 32'sd9, 32'd14);
        send_event(KIND_ABS, CODE_MT_SLOT, 32'(SLOTS - 1), 32'd15);
        send_event(KIND_ABS, CODE_MT_X, 32'h7FFF_FFFF, 32'd16);
        send_event(KIND_ABS, CODE_MT_Y, 32'h8000_0000, 32'd17);
        send_event(KIND_ABS, CODE_MT_ID, -32'sd2, 32'd18);        // not the release id
        send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0, 32'd19);
        send_event(KIND_ABS, CODE_MT_ID, RELEASE_ID, 32'd20);
        send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0, 32'd21);
    endtask

    // Axis and key extremes, key values other than 1, ignored kinds and codes.
    task automatic test_field_extremes();
        send_event(KIND_ABS, CODE_X, 32'h7FFF_FFFF, 32'd30);
        send_event(KIND_ABS, CODE_Y, 32'h8000_0000, 32'd31);
        send_event(KIND_ABS, CODE_PRESSURE, 32'h0000_7FFF, 32'd32);
        send_event(KIND_KEY, CODE_BTN_TOUCH, KEY_DOWN, 32'd33);
        send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0, 32'hFFFF_FFFF);
        send_event(KIND_KEY, CODE_BTN_LEFT, 32'sd2, 32'd34);       // repeat value reads as up
        send_event(5'd31, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // unknown kind
        send_event(KIND_SYN, 10'd1, 32'sd0, 32'd35);               // sync, not a report
        send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0, 32'h0000_0000);
    endtask

    // Swap and both inverts, then zero screen dimensions.
    task automatic test_transform_corners();
        load_setting(24'd3840, 24'd2160, 16'sd0, 16'sd0, 15'd1920, 15'd1080, 4'd7);
        send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0, 32'd40);
        load_setting(24'd3840, 24'd2160, 16'sd100, -16'sd100, 15'd0, 15'd0, 4'd14);
        send_event(KIND_SYN, CODE_SYN_REPORT, 32'sd0, 32'd41);
    endtask

    // Random reports and noise over several settings at one idling mix.
    task automatic test_random_traffic(int send_pct, int recv_pct, int per_setting);
        int k;
        int start;
        for (k = 0; k < 4; k++)
        begin
            case (k)
                0: load_setting(24'hFF_FFFF, 24'hFF_FFFF, 16'sd32767, 16'sd32767,
                                15'd32767, 15'd32767, 4'd15);
                1: load_setting(24'd0, 24'd0, -16'sd32768, -16'sd32768, 15'd1, 15'd1, 4'd0);
                2: load_setting(24'($urandom_range(24'h4_0000)), 24'($urandom_range(24'h4_0000)),
                                16'($urandom), 16'($urandom), 15'($urandom_range(1, 4000)),
                                15'($urandom_range(1, 4000)), 4'($urandom_range(15)) | 4'd8);
                default: load_setting(24'($urandom), 24'($urandom), 16'($urandom), 16'($urandom),
                                      15'($urandom), 15'($urandom), 4'($urandom));
            endcase
            send_idle_pct = send_pct;
            recv_idle_pct = recv_pct;
            start = items_counted;
            while (items_counted - start < per_setting)
            begin
                if ($urandom_range(9) == 0)
                    send_noise_item();
                else
                    send_touch_frame();
                // first setting only: near the halfway count the sender holds off until the block has drained
                if (k == 0 && items_counted - start >= per_setting / 2
                    && items_counted - start < per_setting / 2 + 8)
                    wait_for_points();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        in_valid       = 1'b0;
        ev_kind        = '0;
        ev_code        = '0;
        ev_value       = '0;
        stamp_ms       = '0;
        out_ready      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        items_counted  = 0;
        send_idle_pct  = 10;
        recv_idle_pct  = 68;
        clear_track_state();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_power_on_point();
        test_slot_table();
        test_field_extremes();
        test_transform_corners();
        test_random_traffic(10, 68, 110);
        test_random_traffic(68, 10, 110);
        test_random_traffic(0, 0, 110);

        wait_for_points();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/tesp_pkg.sv
hw/rtl/tesp_ram.sv
hw/rtl/tesp_scale.sv
hw/rtl/tesp_slot.sv
hw/rtl/touch_event_to_screen_point_top.sv
tb/tb_touch_event_to_screen_point_top.sv
